// ===== src/gemm_pkg.sv =====
package gemm_pkg;

	// Field widths shared by the channel interfaces and the datapath
	localparam int B_ROW_W = 8;
	localparam int B_COL_W = 6;
	localparam int ELEM_W  = 8;
	localparam int ROW_W   = 16;
	localparam int INNER_W = 9;
	localparam int COLS_W  = 7;
	localparam int ACC_W   = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Input kinds
	localparam logic KIND_B_WRITE = 1'b0;
	localparam logic KIND_A_ELEM  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_N = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_P  = 2'd2;

	localparam logic [ELEM_W-1:0] SAT_MAX = 8'd255;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_MAC     = 5'b00010,
		ST_MAC_END = 5'b00100,
		ST_EMIT_RD = 5'b01000,
		ST_EMIT_LD = 5'b10000
	} state_t;

endpackage

// ===== src/gemm_if.sv =====
interface gemm_in_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic        [gemm_pkg::B_ROW_W-1:0] b_row;
	logic        [gemm_pkg::B_COL_W-1:0] b_col;
	logic signed [gemm_pkg::ELEM_W-1:0]  b_value;
	logic        [gemm_pkg::ELEM_W-1:0]  a_value;

	modport source (output valid, kind, b_row, b_col, b_value, a_value, input ready);
	modport sink (input valid, kind, b_row, b_col, b_value, a_value, output ready);
endinterface

interface gemm_out_if;
	logic                         valid;
	logic                         ready;
	logic [gemm_pkg::ELEM_W-1:0]  out_value;
	logic [gemm_pkg::ROW_W-1:0]   out_row;
	logic [gemm_pkg::B_COL_W-1:0] out_col;
	logic                         row_last;
	logic                         matrix_last;

	modport source (output valid, out_value, out_row, out_col, row_last, matrix_last,
		input ready);
	modport sink (input valid, out_value, out_row, out_col, row_last, matrix_last,
		output ready);
endinterface

interface gemm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [gemm_pkg::CFG_IDX_W-1:0]  index;
	logic [gemm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/gemm_ram.sv =====
module gemm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/gemm_u8_i8_saturate_u8.sv =====
// Saturating 8-bit matrix product: C = clamp(A x B, 0, 255), A unsigned, B signed.
//
// Channels: din carries one transaction per B entry (kind 0: b_row, b_col, b_value)
// or per A element (kind 1: a_value, row-major order). dout carries result entries
// with row, column, row_last and matrix_last. cfg writes rows_m, inner_n, cols_p
// (index 0, 1, 2) and is always ready; write it only while the block is idle.
//
// Sequence: a B write is taken while idle. An A element (p = cols_p) runs one
// multiply-accumulate per result column on the single shared MAC, fed by the
// registered read ports of the B store and the accumulator RAM, then a drain
// state. The last element of a row then emits p results, each as an accumulator
// read followed by a load into the output register. din is not ready while an
// element is in flight.
//
// Reset clears the counters, sets each size register to one and clears the
// accumulator valid bits; the B store holds garbage until written. When dout
// stalls, the output register holds its entry and emission waits; din is taken
// again as soon as the last entry of a row sits in the output register.
module gemm_u8_i8_saturate_u8 #(
	parameter int MAX_INNER = 256,
	parameter int MAX_COLS  = 64
) (
	input logic            clk,
	input logic            arst_n,
	gemm_in_if.sink        din,
	gemm_out_if.source     dout,
	gemm_cfg_if.sink       cfg
);

	localparam int KW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int IW = $clog2(MAX_INNER + 1);
	localparam int PW = $clog2(MAX_COLS + 1);
	localparam int B_DEPTH = 1 << (KW + CW);

	// Configuration registers
	logic [gemm_pkg::ROW_W-1:0]   rows_m_q;
	logic [gemm_pkg::INNER_W-1:0] inner_n_q;
	logic [gemm_pkg::COLS_W-1:0]  cols_p_q;

	gemm_pkg::state_t state_q;

	logic [KW-1:0]              inner_count_q;
	logic [gemm_pkg::ROW_W-1:0] row_count_q;
	logic [KW-1:0]              k_q;
	logic [gemm_pkg::ELEM_W-1:0] a_q;
	logic [gemm_pkg::ROW_W-1:0] row_q;
	logic                       row_end_q;
	logic                       mat_end_q;
	logic [CW-1:0]              col_q;
	logic [MAX_COLS-1:0]        acc_vld_q;
	logic                       acc_rv_q;

	logic          mac_v_s1;
	logic [CW-1:0] col_s1;

	logic                        out_full_q;
	logic [gemm_pkg::ELEM_W-1:0] out_value_q;
	logic [gemm_pkg::ROW_W-1:0]  out_row_q;
	logic [gemm_pkg::B_COL_W-1:0] out_col_q;
	logic                        row_last_q;
	logic                        matrix_last_q;

	logic [IW-1:0] eff_inner;
	logic [PW-1:0] eff_cols;
	logic [gemm_pkg::ROW_W-1:0] eff_rows;
	logic          in_take;
	logic          b_wr_en;
	logic          a_take;
	logic          row_end;
	logic          mat_end;
	logic          last_col;
	logic          out_load;

	logic [KW+CW-1:0]           b_wr_addr;
	logic [gemm_pkg::ELEM_W-1:0] b_rd;
	logic [gemm_pkg::ACC_W-1:0] acc_rd;
	logic [gemm_pkg::ACC_W-1:0] acc_base;
	logic [gemm_pkg::ACC_W-1:0] acc_sum;
	logic signed [16:0]         prod;
	logic                       acc_rd_en;
	logic [gemm_pkg::ELEM_W-1:0] sat_value;

	// Effective sizes: clamp the registers into the supported range
	always_comb begin
		if (inner_n_q == '0) begin
			eff_inner = IW'(1);
		end else if (32'(inner_n_q) > MAX_INNER) begin
			eff_inner = IW'(MAX_INNER);
		end else begin
			eff_inner = IW'(inner_n_q);
		end
		if (cols_p_q == '0) begin
			eff_cols = PW'(1);
		end else if (32'(cols_p_q) > MAX_COLS) begin
			eff_cols = PW'(MAX_COLS);
		end else begin
			eff_cols = PW'(cols_p_q);
		end
		eff_rows = (rows_m_q == '0) ? gemm_pkg::ROW_W'(1) : rows_m_q;
	end

	assign din.ready = (state_q == gemm_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign in_take   = din.valid && din.ready;
	assign a_take    = in_take && (din.kind == gemm_pkg::KIND_A_ELEM);
	assign b_wr_en   = in_take && (din.kind == gemm_pkg::KIND_B_WRITE)
		&& (32'(din.b_row) < MAX_INNER) && (32'(din.b_col) < MAX_COLS);
	assign b_wr_addr = {KW'(din.b_row), CW'(din.b_col)};

	assign row_end  = (32'(inner_count_q) + 32'd1) >= 32'(eff_inner);
	assign mat_end  = (32'(row_count_q) + 32'd1) >= 32'(eff_rows);
	assign last_col = (32'(col_q) + 32'd1) == 32'(eff_cols);
	assign out_load = (state_q == gemm_pkg::ST_EMIT_LD) && (!out_full_q || dout.ready);

	// B store: written by kind 0 transactions, read one column per cycle in MAC
	gemm_ram #(
		.WIDTH (gemm_pkg::ELEM_W),
		.DEPTH (B_DEPTH)
	) u_b_store (
		.clk     (clk),
		.wr_en   (b_wr_en),
		.wr_addr (b_wr_addr),
		.wr_data (din.b_value),
		.rd_en   (state_q == gemm_pkg::ST_MAC),
		.rd_addr ({k_q, col_q}),
		.rd_data (b_rd)
	);

	// Row accumulators: read at col_q, written back in the next cycle at col_s1
	assign acc_rd_en = (state_q == gemm_pkg::ST_MAC) || (state_q == gemm_pkg::ST_EMIT_RD);

	gemm_ram #(
		.WIDTH (gemm_pkg::ACC_W),
		.DEPTH (MAX_COLS)
	) u_acc (
		.clk     (clk),
		.wr_en   (mac_v_s1),
		.wr_addr (col_s1),
		.wr_data (acc_sum),
		.rd_en   (acc_rd_en),
		.rd_addr (col_q),
		.rd_data (acc_rd)
	);

	// Shared MAC: unsigned A times signed B, added with 32-bit wrap.
	// An accumulator that is not valid in this row reads as zero.
	assign acc_base = acc_rv_q ? acc_rd : '0;
	assign prod     = $signed({9'b0, a_q}) * $signed({{9{b_rd[gemm_pkg::ELEM_W-1]}}, b_rd});
	assign acc_sum  = acc_base + {{(gemm_pkg::ACC_W - 17){prod[16]}}, prod};

	// Clamp the signed sum into 0..255
	always_comb begin
		if (acc_base[gemm_pkg::ACC_W-1]) begin
			sat_value = '0;
		end else if (acc_base[gemm_pkg::ACC_W-2:gemm_pkg::ELEM_W] != '0) begin
			sat_value = gemm_pkg::SAT_MAX;
		end else begin
			sat_value = acc_base[gemm_pkg::ELEM_W-1:0];
		end
	end

	// Configuration writes; out-of-list indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q  <= gemm_pkg::ROW_W'(1);
			inner_n_q <= gemm_pkg::INNER_W'(1);
			cols_p_q  <= gemm_pkg::COLS_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				gemm_pkg::REG_ROWS_M:  rows_m_q  <= cfg.data;
				gemm_pkg::REG_INNER_N: inner_n_q <= cfg.data[gemm_pkg::INNER_W-1:0];
				gemm_pkg::REG_COLS_P:  cols_p_q  <= cfg.data[gemm_pkg::COLS_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= gemm_pkg::ST_IDLE;
			inner_count_q <= '0;
			row_count_q   <= '0;
			col_q         <= '0;
			acc_vld_q     <= '0;
			mac_v_s1      <= 1'b0;
		end else begin
			mac_v_s1 <= (state_q == gemm_pkg::ST_MAC);
			if (mac_v_s1) begin
				acc_vld_q[col_s1] <= 1'b1;
			end
			unique case (state_q)
				gemm_pkg::ST_IDLE: begin
					if (a_take) begin
						col_q         <= '0;
						state_q       <= gemm_pkg::ST_MAC;
						inner_count_q <= row_end ? '0 : KW'(32'(inner_count_q) + 32'd1);
						if (row_end) begin
							row_count_q <= mat_end ? '0 : row_count_q + 1'b1;
						end
					end
				end
				gemm_pkg::ST_MAC: begin
					if (last_col) begin
						state_q <= gemm_pkg::ST_MAC_END;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				gemm_pkg::ST_MAC_END: begin
					col_q   <= '0;
					state_q <= row_end_q ? gemm_pkg::ST_EMIT_RD : gemm_pkg::ST_IDLE;
				end
				gemm_pkg::ST_EMIT_RD: begin
					state_q <= gemm_pkg::ST_EMIT_LD;
				end
				gemm_pkg::ST_EMIT_LD: begin
					if (out_load) begin
						if (last_col) begin
							acc_vld_q <= '0;
							state_q   <= gemm_pkg::ST_IDLE;
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= gemm_pkg::ST_EMIT_RD;
						end
					end
				end
				default: state_q <= gemm_pkg::ST_IDLE;
			endcase
		end
	end

	// Item payload and pipeline stage; no reset needed
	always_ff @(posedge clk) begin
		if (a_take) begin
			a_q       <= din.a_value;
			k_q       <= inner_count_q;
			row_q     <= row_count_q;
			row_end_q <= row_end;
			mat_end_q <= mat_end;
		end
		col_s1 <= col_q;
		if (acc_rd_en) begin
			acc_rv_q <= acc_vld_q[col_q];
		end
	end

	// Output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (out_load) begin
			out_full_q <= 1'b1;
		end else if (dout.ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q   <= sat_value;
			out_row_q     <= row_q;
			out_col_q     <= gemm_pkg::B_COL_W'(col_q);
			row_last_q    <= last_col;
			matrix_last_q <= last_col && mat_end_q;
		end
	end

	assign dout.valid       = out_full_q;
	assign dout.out_value   = out_value_q;
	assign dout.out_row     = out_row_q;
	assign dout.out_col     = out_col_q;
	assign dout.row_last    = row_last_q;
	assign dout.matrix_last = matrix_last_q;

	// An accumulator write-back only follows an issue cycle of the MAC pass
	a_mac_wb: assert property (@(posedge clk) disable iff (!arst_n)
		mac_v_s1 |-> (state_q == gemm_pkg::ST_MAC || state_q == gemm_pkg::ST_MAC_END))
		else $error("accumulator write-back outside the MAC pass");

	// An accepted A element starts the MAC pass at column zero
	a_mac_start: assert property (@(posedge clk) disable iff (!arst_n)
		a_take |=> (state_q == gemm_pkg::ST_MAC && col_q == '0))
		else $error("A element did not start the MAC pass");

	// Loading the last entry of a row clears every accumulator
	a_row_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_col) |=> (acc_vld_q == '0))
		else $error("accumulators not cleared at row end");

	// Emission loads only after an accumulator read
	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == gemm_pkg::ST_EMIT_LD) |-> $past(state_q == gemm_pkg::ST_EMIT_RD))
		else $error("emission load without a preceding read");

endmodule

// ===== tb/sv/gemm_check_pkg.sv =====
`timescale 1ns / 1ps
package gemm_check_pkg;
	import gemm_pkg::*;

	localparam int STORE_ROWS  = 256;
	localparam int STORE_COLS  = 64;
	localparam int STORE_DEPTH = STORE_ROWS * STORE_COLS;
	localparam int REPORT_CAP  = 100;

	typedef struct packed {
		logic                       kind;
		logic [B_ROW_W-1:0]         b_row;
		logic [B_COL_W-1:0]         b_col;
		logic signed [ELEM_W-1:0]   b_value;
		logic [ELEM_W-1:0]          a_value;
	} din_item_t;

	typedef struct packed {
		logic [ELEM_W-1:0]  value;
		logic [ROW_W-1:0]   row;
		logic [B_COL_W-1:0] col;
		logic               row_last;
		logic               matrix_last;
	} out_entry_t;

	class gemm_scoreboard;
		logic signed [ELEM_W-1:0] b_mem [STORE_DEPTH];
		bit                       b_written [STORE_DEPTH];
		int                       row_acc [STORE_COLS];
		int unsigned              inner_cnt;
		int unsigned              row_cnt;
		logic [ROW_W-1:0]         rows_m;
		logic [INNER_W-1:0]       inner_n;
		logic [COLS_W-1:0]        cols_p;
		out_entry_t               pending_entries [$];
		int unsigned              errors;
		int unsigned              entries_checked;
		int unsigned              b_writes;
		int unsigned              a_elems;

		function new();
			foreach (b_written[i]) b_written[i] = 1'b0;
			foreach (row_acc[i]) row_acc[i] = 0;
			inner_cnt = 0;
			row_cnt = 0;
			rows_m = 1;
			inner_n = 1;
			cols_p = 1;
			errors = 0;
			entries_checked = 0;
			b_writes = 0;
			a_elems = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ROWS_M:  rows_m = data[ROW_W-1:0];
				REG_INNER_N: inner_n = data[INNER_W-1:0];
				REG_COLS_P:  cols_p = data[COLS_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_inner();
			if (inner_n == 0) return 1;
			if (inner_n > STORE_ROWS) return STORE_ROWS;
			return inner_n;
		endfunction

		function int unsigned eff_cols();
			if (cols_p == 0) return 1;
			if (cols_p > STORE_COLS) return STORE_COLS;
			return cols_p;
		endfunction

		function int unsigned eff_rows();
			return (rows_m == 0) ? 1 : rows_m;
		endfunction

		// B row that the next A element multiplies with
		function int unsigned read_row();
			return (inner_cnt >= STORE_ROWS) ? STORE_ROWS - 1 : inner_cnt;
		endfunction

		function void note_input(din_item_t it);
			int unsigned p;
			int unsigned k;
			int unsigned j;
			bit          end_m;
			int          v;
			out_entry_t  e;
			p = eff_cols();
			if (it.kind == KIND_B_WRITE) begin
				b_writes++;
				if (it.b_row < STORE_ROWS && it.b_col < STORE_COLS) begin
					b_mem[it.b_row * STORE_COLS + it.b_col] = it.b_value;
					b_written[it.b_row * STORE_COLS + it.b_col] = 1'b1;
				end
				return;
			end
			a_elems++;
			k = read_row();
			for (j = 0; j < p; j++)
				row_acc[j] += int'(it.a_value) * int'(b_mem[k * STORE_COLS + j]);
			if (inner_cnt + 1 < eff_inner()) begin
				inner_cnt++;
				return;
			end
			end_m = (row_cnt + 1 >= eff_rows());
			for (j = 0; j < p; j++) begin
				v = row_acc[j];
				if (v > int'(SAT_MAX)) e.value = SAT_MAX;
				else if (v < 0) e.value = '0;
				else e.value = v[ELEM_W-1:0];
				e.row = row_cnt[ROW_W-1:0];
				e.col = j[B_COL_W-1:0];
				e.row_last = (j + 1 == p);
				e.matrix_last = e.row_last && end_m;
				pending_entries.push_back(e);
			end
			foreach (row_acc[i]) row_acc[i] = 0;
			inner_cnt = 0;
			row_cnt = end_m ? 0 : ((row_cnt + 1) & 32'hFFFF);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= REPORT_CAP) $display("mismatch: %s", msg);
		endtask

		task check_entry(out_entry_t got);
			out_entry_t want;
			if (pending_entries.size() == 0) begin
				report($sformatf("unexpected entry row %0d col %0d value %0d",
					got.row, got.col, got.value));
				return;
			end
			want = pending_entries.pop_front();
			entries_checked++;
			if (got.value !== want.value)
				report($sformatf("row %0d col %0d: value %0d, want %0d",
					want.row, want.col, got.value, want.value));
			if (got.row !== want.row)
				report($sformatf("row %0d col %0d: out_row %0d", want.row, want.col, got.row));
			if (got.col !== want.col)
				report($sformatf("row %0d col %0d: out_col %0d", want.row, want.col, got.col));
			if (got.row_last !== want.row_last)
				report($sformatf("row %0d col %0d: row_last %b, want %b",
					want.row, want.col, got.row_last, want.row_last));
			if (got.matrix_last !== want.matrix_last)
				report($sformatf("row %0d col %0d: matrix_last %b, want %b",
					want.row, want.col, got.matrix_last, want.matrix_last));
		endtask

		task finish_check();
			if (pending_entries.size() != 0)
				report($sformatf("%0d result entries never arrived", pending_entries.size()));
		endtask
	endclass
endpackage

// ===== tb/sv/gemm_u8_i8_saturate_u8_tb.sv =====
`timescale 1ns / 1ps
module gemm_u8_i8_saturate_u8_tb;
	import gemm_pkg::*;
	import gemm_check_pkg::*;

	// Margin that lets any element in flight finish before a register write
	localparam int SETTLE_CYCLES = 2 * STORE_COLS + 16;
	// Receiver hold-off that backs results up into the input channel
	localparam int HOLD_CYCLES   = 3000;
	// Random transactions per idling segment, extremes not counted
	localparam int SEGMENT_ITEMS = 80;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_LIMIT   = 200000;

	logic clk;
	logic arst_n;

	gemm_in_if  din_if ();
	gemm_out_if dout_if ();
	gemm_cfg_if cfg_if ();

	gemm_u8_i8_saturate_u8 #(
		.MAX_INNER(STORE_ROWS),
		.MAX_COLS (STORE_COLS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_if),
		.dout  (dout_if),
		.cfg   (cfg_if)
	);

	gemm_scoreboard sb;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          hold_req;
	int unsigned cycle_count;
	int unsigned cfg_writes;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if the block hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[gemm_u8_i8_saturate_u8] ERROR");
		$finish;
	end

	// Receiver: drive ready at the falling edge. A hold request keeps ready low until
	// the hold count, kept here, reaches HOLD_CYCLES, while the sender keeps offering transactions.
	initial begin
		int unsigned hold_count;
		hold_count = 0;
		dout_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_count < HOLD_CYCLES) begin
				dout_if.ready = 1'b0;
				hold_count++;
			end else begin
				dout_if.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Check every result transaction at the rising edge against the oldest expectation
	always @(posedge clk) begin
		out_entry_t got;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			got.value = dout_if.out_value;
			got.row = dout_if.out_row;
			got.col = dout_if.out_col;
			got.row_last = dout_if.row_last;
			got.matrix_last = dout_if.matrix_last;
			sb.check_entry(got);
		end
	end

	function automatic logic signed [ELEM_W-1:0] rand_b();
		// Mix full-range entries (saturating sums) with small ones (in-range sums)
		if ($urandom_range(1) == 0) return 8'($urandom);
		return 8'($urandom_range(8) - 4);
	endfunction

	function automatic logic [ELEM_W-1:0] rand_a();
		case ($urandom_range(5))
			0: return '0;
			1: return SAT_MAX;
			2: return 8'($urandom_range(15));
			default: return 8'($urandom);
		endcase
	endfunction

	// Unused payload fields carry random values so the block must ignore them
	function automatic din_item_t b_item(input int unsigned r, input int unsigned c,
			input logic signed [ELEM_W-1:0] v);
		din_item_t it;
		it.kind = KIND_B_WRITE;
		it.b_row = r[B_ROW_W-1:0];
		it.b_col = c[B_COL_W-1:0];
		it.b_value = v;
		it.a_value = 8'($urandom);
		return it;
	endfunction

	function automatic din_item_t a_item(input logic [ELEM_W-1:0] a);
		din_item_t it;
		it.kind = KIND_A_ELEM;
		it.b_row = 8'($urandom);
		it.b_col = 6'($urandom);
		it.b_value = 8'($urandom);
		it.a_value = a;
		return it;
	endfunction

	// Offer one input transaction after a random gap; hold it until accepted
	task automatic send_item(input din_item_t it);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		@(negedge clk);
		if (gap != 0) begin
			din_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		din_if.valid = 1'b1;
		din_if.kind = it.kind;
		din_if.b_row = it.b_row;
		din_if.b_col = it.b_col;
		din_if.b_value = it.b_value;
		din_if.a_value = it.a_value;
		@(posedge clk);
		while (!din_if.ready) @(posedge clk);
		sb.note_input(it);
	endtask

	// Send an A element; first fill any B entry of its row that was never written
	task automatic push_a(input logic [ELEM_W-1:0] a);
		int unsigned k;
		int unsigned p;
		int unsigned j;
		k = sb.read_row();
		p = sb.eff_cols();
		for (j = 0; j < p; j++)
			if (!sb.b_written[k * STORE_COLS + j]) send_item(b_item(k, j, rand_b()));
		send_item(a_item(a));
	endtask

	// A elements with occasional stray B writes anywhere in the store
	task automatic run_stream(input int unsigned count);
		int unsigned i;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0)
				send_item(b_item($urandom_range(STORE_ROWS - 1), $urandom_range(STORE_COLS - 1),
					8'($urandom)));
			push_a(rand_a());
		end
	endtask

	// Drop valid and wait until every result is in and no element is in flight
	task automatic settle();
		@(negedge clk);
		din_if.valid = 1'b0;
		while (sb.pending_entries.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		sb.set_reg(idx, val);
		cfg_writes++;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] m, input logic [CFG_DATA_W-1:0] n,
			input logic [CFG_DATA_W-1:0] p);
		settle();
		write_reg(REG_ROWS_M, m);
		write_reg(REG_INNER_N, n);
		write_reg(REG_COLS_P, p);
	endtask

	// Mostly small sizes, now and then a zero or a wider size; mostly whole matrices,
	// sometimes a cut-off one that leaves the counters mid-row for the next setting
	task automatic random_phase();
		logic [CFG_DATA_W-1:0] m;
		logic [CFG_DATA_W-1:0] n;
		logic [CFG_DATA_W-1:0] p;
		int unsigned           full;
		int unsigned           elems;
		m = 16'($urandom_range(1, 4));
		n = 16'($urandom_range(1, 6));
		p = 16'($urandom_range(1, 8));
		case ($urandom_range(11))
			0: m = '0;
			1: n = '0;
			2: p = '0;
			3: p = 16'($urandom_range(9, 64));
			4: n = 16'($urandom_range(7, 24));
			default: ;
		endcase
		set_config(m, n, p);
		full = sb.eff_rows() * sb.eff_inner();
		if ($urandom_range(4) != 0) elems = full;
		else elems = $urandom_range(1, full + 3);
		run_stream(elems);
	endtask

	initial begin
		int unsigned seg;
		int unsigned start;
		int unsigned waited;

		sb = new();
		send_idle_pct = 38;
		recv_idle_pct = 64;
		hold_req = 1'b0;
		cfg_writes = 0;
		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.kind = KIND_B_WRITE;
		din_if.b_row = '0;
		din_if.b_col = '0;
		din_if.b_value = '0;
		din_if.a_value = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_ROWS_M;
		cfg_if.data = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extreme entries, saturation at both ends, an exact mid-range sum
		set_config(2, 2, 3);
		send_item(b_item(0, 0, 127));
		send_item(b_item(0, 1, -128));
		send_item(b_item(0, 2, 1));
		send_item(b_item(1, 0, 127));
		send_item(b_item(1, 1, -128));
		send_item(b_item(1, 2, 0));
		push_a(SAT_MAX);
		push_a(SAT_MAX);
		push_a('0);
		push_a(1);
		// Far corner of the store
		send_item(b_item(STORE_ROWS - 1, STORE_COLS - 1, -1));

		// Zero rows acts as one: every element closes a whole matrix
		set_config(0, 1, 1);
		push_a(1);
		push_a(200);

		// Shrink the inner size mid-row: the next element ends the row past the limit
		set_config(1, 3, 2);
		push_a(7);
		push_a(9);
		settle();
		write_reg(REG_INNER_N, 1);
		push_a(3);

		// Random part in three idling segments, each opening with extreme sizes
		for (seg = 0; seg < 3; seg++) begin
			case (seg)
				0: begin
					send_idle_pct = 38;
					recv_idle_pct = 64;
					// Widest row, clamped to 64 columns; matrix left unfinished
					set_config(16'hFFFF, 1, 16'h007F);
					run_stream(4);
				end
				1: begin
					send_idle_pct = 64;
					recv_idle_pct = 38;
					set_config(2, 1, STORE_COLS);
					run_stream(2);
					// Upper data bits beyond the register width are dropped
					set_config(3, 2, 16'hFF83);
					run_stream(6);
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					// Inner size past the store and zero columns both clamp; leave the
					// row open so the next setting closes it past its limit
					set_config(0, 300, 0);
					run_stream(24);
					// Back up the output with a long receiver hold-off
					set_config(4, 2, 8);
					hold_req = 1'b1;
					run_stream(8);
				end
			endcase
			start = sb.b_writes + sb.a_elems;
			while (sb.b_writes + sb.a_elems - start < SEGMENT_ITEMS) random_phase();
		end

		// Drain, then leave time for any stray result
		@(negedge clk);
		din_if.valid = 1'b0;
		waited = 0;
		while (sb.pending_entries.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.finish_check();

		$display("Covered %0d B writes, %0d A elements, %0d checked result entries",
			sb.b_writes, sb.a_elems, sb.entries_checked);
		$display("over %0d register writes incl. clamped sizes, 64-column rows, a long stall",
			cfg_writes);
		if (sb.errors == 0) begin
			$display("[gemm_u8_i8_saturate_u8] OK");
		end else begin
			$display("[gemm_u8_i8_saturate_u8] ERROR");
		end
		$finish;
	end

endmodule
